### rtl/core/h2t_pkg.sv
// Package with the shared types, constants and lookup functions of the HTML text stripper.
`default_nettype none

package h2t_pkg;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_TEXT  = 3'd0,
    MODE_ENT   = 3'd1,
    MODE_OPEN  = 3'd2,
    MODE_TAG   = 3'd3,
    MODE_BLOCK = 3'd4
  } mode_e;

  // Characters with a special role.
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;

  // Number of known entities and the index of the one that decodes to a space.
  localparam int unsigned NumEnt = 6;
  localparam logic [2:0]  EntNbsp = 3'd5;

  // Slots of one request in output order.
  localparam int unsigned NumSlots = 7;
  localparam logic [2:0]  SlotAmp  = 3'd0;
  localparam logic [2:0]  SlotChar = 3'd5;
  localparam logic [2:0]  SlotDone = 3'd6;

  // Results caused by one input byte, in the order they leave the block:
  // an ampersand, up to four held bytes, one character, the end marker.
  typedef struct packed {
    logic            amp;
    logic [2:0]      nheld;
    logic [3:0][7:0] held;
    logic            has_char;
    logic [7:0]      chr;
    logic            done;
  } cmd_t;

  // Body of entity k after the ampersand; element 0 is the first byte.
  function automatic logic [4:0][7:0] ent_body(input logic [2:0] k);
    logic [4:0][7:0] b;
    unique case (k)
      3'd0:    b = {ChNul, ";", "p", "m", "a"};
      3'd1:    b = {ChNul, ChNul, ";", "t", "l"};
      3'd2:    b = {ChNul, ChNul, ";", "t", "g"};
      3'd3:    b = {";", "t", "o", "u", "q"};
      3'd4:    b = {ChNul, ";", "9", "3", "#"};
      3'd5:    b = {";", "p", "s", "b", "n"};
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] k);
    logic [2:0] n;
    unique case (k)
      3'd0:    n = 3'd4;
      3'd1:    n = 3'd3;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd5;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = ChAmp;
      3'd1:    c = ChLt;
      3'd2:    c = ChGt;
      3'd3:    c = 8'h22;
      3'd4:    c = 8'h27;
      3'd5:    c = ChSpace;
      default: c = ChNul;
    endcase
    return c;
  endfunction

  // Tag names and closing tags, element 0 first.
  localparam logic [5:0][7:0] OpenScript  = {"t", "p", "i", "r", "c", "s"};
  localparam logic [4:0][7:0] OpenStyle   = {"e", "l", "y", "t", "s"};
  localparam logic [7:0][7:0] CloseScript = {"t", "p", "i", "r", "c", "s", "/", "<"};
  localparam logic [6:0][7:0] CloseStyle  = {"e", "l", "y", "t", "s", "/", "<"};

  function automatic logic [7:0] lower_ascii(input logic [7:0] v);
    return (v >= "A" && v <= "Z") ? v + 8'd32 : v;
  endfunction

  function automatic logic is_white(input logic [7:0] v);
    return (v == ChSpace) || (v >= 8'd9 && v <= 8'd13);
  endfunction

endpackage

`default_nettype wire

### rtl/core/h2t_stream_if.sv
// Stream interfaces for the input bytes and the plain text results.
`default_nettype none

interface h2t_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface h2t_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_char, output char_valid, output run_last,
                  output text_done, input ready);
  modport sink (input valid, input out_char, input char_valid, input run_last,
                input text_done, output ready);
endinterface

`default_nettype wire

### rtl/core/html_to_text_stripper.sv
// Top level of the HTML to plain text stripper.
//
// The in_i channel takes one HTML byte per request together with an end of
// text flag; the out_o channel gives plain text bytes, each with char_valid,
// run_last on the last result of its input byte, and text_done on the bare
// end marker that closes a text. Both channels use valid/ready.
// The front end parses one byte per cycle while the queue has room, and queues
// the results of each byte as one request in a two-entry queue; the back end
// sends those results one per cycle while the receiver is ready. The results
// of a byte pass through the queue and the back end's request register first.
// A byte causes zero to seven results, so the input runs at one byte per
// cycle as long as bytes average at most one result; an entity flush (up to
// seven results) can hold the input while the back end drains the queue.
// While the receiver stalls, the queue fills and then the input stalls; no
// result is lost or repeated. Reset puts the parser in text mode and empties
// the queue and the output stage; the block is ready at once.
`default_nettype none

module html_to_text_stripper
  import h2t_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  h2t_in_if.sink    in_i,
  h2t_out_if.source out_o
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  h2t_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  h2t_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (front_cmd),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_data_o  (back_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  h2t_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### rtl/core/h2t_front.sv
// Front end: parses each input byte and turns it into at most one output request.
`default_nettype none

module h2t_front
  import h2t_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  h2t_in_if.sink    in_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  wire logic cmd_ready_i
);

  mode_e           mode_q, mode_d;
  logic            prev_space_q, prev_space_d;
  logic [3:0][7:0] held_q, held_d;
  logic [2:0]      hcnt_q, hcnt_d;
  logic [2:0]      mp_q, mp_d;
  logic            is_style_q, is_style_d;
  logic [1:0]      cand_q, cand_d;

  logic [7:0] v;
  logic [7:0] lv;
  logic       accept;
  logic       do_plain;
  logic       flushed;
  logic [2:0] ent_n;
  logic       matched;
  logic       ok;
  logic [2:0] hit;
  logic [1:0] alive;
  logic [3:0] mp_inc;
  logic       blk_hit;
  logic [4:0][7:0] body;
  cmd_t       cmd;

  assign v      = in_i.text_byte;
  assign lv     = lower_ascii(v);
  assign accept = in_i.valid && in_i.ready;

  // Parser next state and the results this byte causes.
  always_comb begin
    mode_d       = mode_q;
    prev_space_d = prev_space_q;
    held_d       = held_q;
    hcnt_d       = hcnt_q;
    mp_d         = mp_q;
    is_style_d   = is_style_q;
    cand_d       = cand_q;
    cmd          = '0;
    do_plain     = 1'b0;
    flushed      = 1'b0;
    matched      = 1'b0;
    ok           = 1'b0;
    hit          = '0;
    alive        = '0;
    blk_hit      = 1'b0;
    body         = '0;
    ent_n        = hcnt_q + 3'd1;
    mp_inc       = {1'b0, mp_q} + 4'd1;

    if (v != ChNul) begin
      unique case (mode_q)
        MODE_TEXT: begin
          do_plain = 1'b1;
        end
        MODE_ENT: begin
          // First entity whose body still agrees with the held bytes and this one.
          for (int k = 0; k < NumEnt; k++) begin
            if (!matched && ent_n <= ent_len(3'(k))) begin
              body = ent_body(3'(k));
              ok   = (body[ent_n - 3'd1] == v);
              for (int j = 0; j < 4; j++) begin
                if (3'(j + 1) < ent_n && held_q[j] != body[j]) begin
                  ok = 1'b0;
                end
              end
              if (ok) begin
                matched = 1'b1;
                hit     = 3'(k);
              end
            end
          end
          if (matched) begin
            if (ent_n == ent_len(hit)) begin
              cmd.has_char = 1'b1;
              cmd.chr      = ent_char(hit);
              prev_space_d = (hit == EntNbsp);
              hcnt_d       = '0;
              mode_d       = MODE_TEXT;
            end else begin
              held_d[hcnt_q[1:0]] = v;
              hcnt_d              = hcnt_q + 3'd1;
            end
          end else begin
            // Mismatch: the pending text goes out unchanged, then the byte as text.
            cmd.amp      = 1'b1;
            cmd.held     = held_q;
            cmd.nheld    = hcnt_q;
            prev_space_d = 1'b0;
            hcnt_d       = '0;
            mode_d       = MODE_TEXT;
            flushed      = 1'b1;
            do_plain     = 1'b1;
          end
        end
        MODE_OPEN: begin
          alive[0] = cand_q[0] && (mp_q < 3'd6) && (lv == OpenScript[mp_q]);
          alive[1] = cand_q[1] && (mp_q < 3'd5) && (lv == OpenStyle[mp_q]);
          if (alive == 2'b00) begin
            mode_d = (v == ChGt) ? MODE_TEXT : MODE_TAG;
            mp_d   = '0;
            cand_d = '0;
          end else if (alive[0] && mp_inc == 4'd6) begin
            mode_d     = MODE_BLOCK;
            is_style_d = 1'b0;
            mp_d       = '0;
            cand_d     = '0;
          end else if (alive[1] && mp_inc == 4'd5) begin
            mode_d     = MODE_BLOCK;
            is_style_d = 1'b1;
            mp_d       = '0;
            cand_d     = '0;
          end else begin
            cand_d = alive;
            mp_d   = mp_inc[2:0];
          end
        end
        MODE_TAG: begin
          if (v == ChGt) begin
            mode_d = MODE_TEXT;
          end
        end
        MODE_BLOCK: begin
          // Track progress through the closing tag of the open block.
          if (is_style_q) begin
            blk_hit = (mp_q < 3'd7) && (lv == CloseStyle[mp_q]);
          end else begin
            blk_hit = (lv == CloseScript[mp_q]);
          end
          if (blk_hit) begin
            if ((is_style_q && mp_inc == 4'd7) || (!is_style_q && mp_inc == 4'd8)) begin
              mode_d = MODE_TAG;
              mp_d   = '0;
            end else begin
              mp_d = mp_inc[2:0];
            end
          end else begin
            mp_d = (v == ChLt) ? 3'd1 : 3'd0;
          end
        end
        default: begin
          mode_d = MODE_TEXT;
        end
      endcase
    end

    // Plain text handling, also for the byte that broke an entity.
    if (do_plain) begin
      if (v == ChLt) begin
        mode_d = MODE_OPEN;
        mp_d   = '0;
        cand_d = 2'b11;
      end else if (v == ChAmp) begin
        mode_d = MODE_ENT;
        hcnt_d = '0;
      end else if (is_white(v)) begin
        if (!prev_space_d) begin
          cmd.has_char = 1'b1;
          cmd.chr      = ChSpace;
          prev_space_d = 1'b1;
        end
      end else begin
        cmd.has_char = 1'b1;
        cmd.chr      = v;
        prev_space_d = 1'b0;
      end
    end

    // End of text: release a pending entity, add the marker, reset the parser.
    if (in_i.end_of_text) begin
      if (mode_d == MODE_ENT) begin
        if (flushed) begin
          cmd.has_char = 1'b1;
          cmd.chr      = ChAmp;
        end else begin
          cmd.amp   = 1'b1;
          cmd.held  = held_d;
          cmd.nheld = hcnt_d;
        end
      end
      cmd.done     = 1'b1;
      mode_d       = MODE_TEXT;
      prev_space_d = 1'b1;
      hcnt_d       = '0;
      mp_d         = '0;
      is_style_d   = 1'b0;
      cand_d       = '0;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = in_i.valid && (cmd.amp || cmd.has_char || cmd.done);
  assign in_i.ready  = cmd_ready_i;

  // Parser control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_TEXT;
      prev_space_q <= 1'b1;
      hcnt_q       <= '0;
      mp_q         <= '0;
      is_style_q   <= 1'b0;
      cand_q       <= '0;
    end else if (accept) begin
      mode_q       <= mode_d;
      prev_space_q <= prev_space_d;
      hcnt_q       <= hcnt_d;
      mp_q         <= mp_d;
      is_style_q   <= is_style_d;
      cand_q       <= cand_d;
    end
  end

  // Held entity bytes carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/h2t_cmd_fifo.sv
// Two-entry queue of output requests between the front and back ends.
`default_nettype none

module h2t_cmd_fifo
  import h2t_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      wr_data_i,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  output cmd_t      rd_data_o,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/h2t_back.sv
// Back end: expands each request into its result items, one per cycle while the receiver is ready.
`default_nettype none

module h2t_back
  import h2t_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  h2t_out_if.source out_o
);

  cmd_t                  cmd_q;
  logic [NumSlots-1:0]   mask_q, mask_d;
  logic [NumSlots-1:0]   load_mask;
  logic [NumSlots-1:0]   rest;
  logic [2:0]            slot;
  logic                  emit;
  logic                  load;

  // Slots present in the incoming request.
  always_comb begin
    load_mask           = '0;
    load_mask[SlotAmp]  = cmd_i.amp;
    for (int j = 0; j < 4; j++) begin
      load_mask[j + 1] = (cmd_i.nheld > 3'(j));
    end
    load_mask[SlotChar] = cmd_i.has_char;
    load_mask[SlotDone] = cmd_i.done;
  end

  // Lowest pending slot goes out first.
  always_comb begin
    slot = SlotDone;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (mask_q[s]) begin
        slot = 3'(s);
      end
    end
  end

  assign rest        = mask_q & ~(NumSlots'(1) << slot);
  assign emit        = out_o.valid && out_o.ready;
  assign cmd_ready_o = (mask_q == '0) || (emit && rest == '0);
  assign load        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    if (load) begin
      mask_d = load_mask;
    end else if (emit) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
  end

  // Result fields for the current slot.
  assign out_o.valid      = (mask_q != '0);
  assign out_o.run_last   = (rest == '0);
  assign out_o.text_done  = (slot == SlotDone);
  assign out_o.char_valid = (slot != SlotDone);

  always_comb begin
    unique case (slot)
      3'd0:    out_o.out_char = ChAmp;
      3'd1:    out_o.out_char = cmd_q.held[0];
      3'd2:    out_o.out_char = cmd_q.held[1];
      3'd3:    out_o.out_char = cmd_q.held[2];
      3'd4:    out_o.out_char = cmd_q.held[3];
      3'd5:    out_o.out_char = cmd_q.chr;
      default: out_o.out_char = ChNul;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### bench/h2t_text_checker.sv
// Checker that predicts the plain text of the HTML stripper and compares every result.
module h2t_text_checker
  import h2t_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  h2t_in_if           in_mon,
  h2t_out_if          out_mon,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One plain text result as it leaves the block.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_done;
  } text_res_t;

  // Tag names and closing tags, element 0 first.
  localparam logic [0:5][7:0] TagScript   = "script";
  localparam logic [0:4][7:0] TagStyle    = "style";
  localparam logic [0:7][7:0] CloseScript = "</script";
  localparam logic [0:6][7:0] CloseStyle  = "</style";
  localparam int unsigned     MaxPerByte  = 7;

  text_res_t   plain_text_q[$];
  text_res_t   byte_res_q[$];
  int unsigned err_n = 0;
  int unsigned pending_n = 0;

  // Shadow parser state.
  mode_e       mode;
  logic        ws_seen;
  logic [7:0]  amp_buf [4];
  int unsigned amp_n;
  int unsigned match_n;
  logic        in_style;
  logic [1:0]  name_cand;

  assign err_count_o = err_n;
  assign pending_o   = pending_n;

  function automatic logic [7:0] to_lower(logic [7:0] v);
    return (v >= "A" && v <= "Z") ? v + 8'd32 : v;
  endfunction

  function automatic logic is_blank(logic [7:0] v);
    return v == ChSpace || (v >= 8'd9 && v <= 8'd13);
  endfunction

  // Entity body after the ampersand, element 0 first, with its length.
  function automatic logic [0:4][7:0] ent_text(int unsigned k);
    case (k)
      0:       return {"amp;", 8'h00};
      1:       return {"lt;", 16'h0000};
      2:       return {"gt;", 16'h0000};
      3:       return "quot;";
      4:       return {"#39;", 8'h00};
      default: return "nbsp;";
    endcase
  endfunction

  function automatic int unsigned ent_size(int unsigned k);
    case (k)
      1, 2:    return 3;
      0, 4:    return 4;
      default: return 5;
    endcase
  endfunction

  function automatic logic [7:0] ent_glyph(int unsigned k);
    case (k)
      0:       return ChAmp;
      1:       return ChLt;
      2:       return ChGt;
      3:       return 8'h22;
      4:       return 8'h27;
      default: return ChSpace;
    endcase
  endfunction

  function automatic void clear_parser();
    mode      = MODE_TEXT;
    ws_seen   = 1'b1;
    amp_n     = 0;
    match_n   = 0;
    in_style  = 1'b0;
    name_cand = 2'b00;
    foreach (amp_buf[i]) amp_buf[i] = 8'h00;
  endfunction

  function automatic void emit(logic [7:0] ch, logic vld, logic done);
    if (byte_res_q.size() < MaxPerByte) byte_res_q.push_back('{ch, vld, 1'b0, done});
  endfunction

  // Plain text: start of a tag or entity, whitespace folding, or a copied byte.
  function automatic void text_in(logic [7:0] v);
    if (v == ChLt) begin
      mode      = MODE_OPEN;
      match_n   = 0;
      name_cand = 2'b11;
    end else if (v == ChAmp) begin
      mode  = MODE_ENT;
      amp_n = 0;
    end else if (is_blank(v)) begin
      if (!ws_seen) begin
        emit(ChSpace, 1'b1, 1'b0);
        ws_seen = 1'b1;
      end
    end else begin
      emit(v, 1'b1, 1'b0);
      ws_seen = 1'b0;
    end
  endfunction

  // Give back the ampersand and the held bytes unchanged.
  function automatic void flush_amp();
    emit(ChAmp, 1'b1, 1'b0);
    for (int unsigned j = 0; j < amp_n; j++) emit(amp_buf[j], 1'b1, 1'b0);
    ws_seen = 1'b0;
    amp_n   = 0;
    mode    = MODE_TEXT;
  endfunction

  // Extend a pending entity; the first entity that still fits wins.
  function automatic void entity_in(logic [7:0] v);
    logic [0:4][7:0] body;
    int unsigned     n;
    logic            ok;
    logic            hit;
    n   = amp_n + 1;
    hit = 1'b0;
    for (int unsigned k = 0; k < 6 && !hit; k++) begin
      body = ent_text(k);
      if (n <= ent_size(k)) begin
        ok = (body[n-1] == v);
        for (int unsigned j = 0; j + 1 < n; j++) begin
          if (amp_buf[j] != body[j]) ok = 1'b0;
        end
        if (ok) begin
          hit = 1'b1;
          if (n == ent_size(k)) begin
            emit(ent_glyph(k), 1'b1, 1'b0);
            ws_seen = (k == EntNbsp);
            amp_n   = 0;
            mode    = MODE_TEXT;
          end else begin
            amp_buf[amp_n] = v;
            amp_n++;
          end
        end
      end
    end
    if (!hit) begin
      flush_amp();
      text_in(v);
    end
  endfunction

  // Tag name check for script and style blocks.
  function automatic void open_in(logic [7:0] v);
    logic [7:0] l;
    logic [1:0] alive;
    l     = to_lower(v);
    alive = 2'b00;
    if (name_cand[0] && match_n < 6 && l == TagScript[match_n]) alive[0] = 1'b1;
    if (name_cand[1] && match_n < 5 && l == TagStyle[match_n]) alive[1] = 1'b1;
    match_n++;
    if (alive == 2'b00) begin
      mode      = (v == ChGt) ? MODE_TEXT : MODE_TAG;
      match_n   = 0;
      name_cand = 2'b00;
    end else if (alive[0] && match_n == 6) begin
      mode      = MODE_BLOCK;
      in_style  = 1'b0;
      match_n   = 0;
      name_cand = 2'b00;
    end else if (alive[1] && match_n == 5) begin
      mode      = MODE_BLOCK;
      in_style  = 1'b1;
      match_n   = 0;
      name_cand = 2'b00;
    end else begin
      name_cand = alive;
    end
  endfunction

  // Search for the closing tag of the open block.
  function automatic void block_in(logic [7:0] v);
    int unsigned plen;
    logic [7:0]  want;
    plen = in_style ? 7 : 8;
    want = 8'h00;
    if (match_n < plen) want = in_style ? CloseStyle[match_n] : CloseScript[match_n];
    if (match_n < plen && to_lower(v) == want) match_n++;
    else match_n = (v == ChLt) ? 1 : 0;
    if (match_n >= plen) begin
      mode    = MODE_TAG;
      match_n = 0;
    end
  endfunction

  // Work out every result caused by one input byte.
  function automatic void predict_plain_text(logic [7:0] b, logic eot);
    byte_res_q.delete();
    if (b != ChNul) begin
      case (mode)
        MODE_ENT:   entity_in(b);
        MODE_OPEN:  open_in(b);
        MODE_TAG:   if (b == ChGt) mode = MODE_TEXT;
        MODE_BLOCK: block_in(b);
        default:    text_in(b);
      endcase
    end
    if (eot) begin
      if (mode == MODE_ENT) flush_amp();
      emit(ChNul, 1'b0, 1'b1);
      clear_parser();
    end
    if (byte_res_q.size() > 0) byte_res_q[byte_res_q.size()-1].run_last = 1'b1;
    foreach (byte_res_q[i]) plain_text_q.push_back(byte_res_q[i]);
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      err_n++;
    end
  endfunction

  // Results are compared before the prediction of a request taken at the same edge,
  // since a byte never shows a result in the cycle it is taken.
  always @(posedge clk_i) begin
    text_res_t want;
    if (!rst_ni) begin
      clear_parser();
      plain_text_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (plain_text_q.size() == 0) begin
          $error("unexpected result: out_char %0h text_done %0b",
                 out_mon.out_char, out_mon.text_done);
          err_n++;
        end else begin
          want = plain_text_q.pop_front();
          check_field("out_char", want.out_char, out_mon.out_char);
          check_field("char_valid", want.char_valid, out_mon.char_valid);
          check_field("run_last", want.run_last, out_mon.run_last);
          check_field("text_done", want.text_done, out_mon.text_done);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_plain_text(in_mon.text_byte, in_mon.end_of_text);
      end
    end
    pending_n = plain_text_q.size();
  end

endmodule

### bench/tb.sv
// Testbench top: drives HTML text into the stripper and gives the verdict.
module tb
  import h2t_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 270;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;

  logic        clk;
  logic        rst_n;
  int unsigned err_n;
  int unsigned pending_n;
  int unsigned quiet_n = 0;
  int unsigned sent_n = 0;
  logic [7:0]  doc_q[$];
  string       ent_names [6] = '{"amp;", "lt;", "gt;", "quot;", "#39;", "nbsp;"};
  string       tag_names [8] = '{"b", "p", "div", "span", "sc", "sty", "a", "br"};

  h2t_in_if  in_bus ();
  h2t_out_if out_bus ();

  html_to_text_stripper u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  h2t_text_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .err_count_o (err_n),
    .pending_o   (pending_n)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Text building helpers.
  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  function automatic void push_mixed(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - 8'd32;
      doc_q.push_back(c);
    end
  endfunction

  function automatic logic [7:0] rand_printable();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    if (c == ChLt || c == ChAmp) c = "x";
    return c;
  endfunction

  function automatic void add_word();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(9) == 0) doc_q.push_back(8'($urandom_range(128, 255)));
      else doc_q.push_back(rand_printable());
    end
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(1) == 0) doc_q.push_back(ChSpace);
      else doc_q.push_back(8'($urandom_range(9, 13)));
    end
  endfunction

  // Whole entities half of the time, otherwise a prefix, possibly broken by a stray byte.
  function automatic void add_entity();
    string       s;
    int unsigned cut;
    s = ent_names[$urandom_range(5)];
    doc_q.push_back(ChAmp);
    case ($urandom_range(3))
      0, 1: push_str(s);
      2: begin
        cut = $urandom_range(0, s.len() - 1);
        for (int unsigned i = 0; i < cut; i++) doc_q.push_back(s[i]);
        doc_q.push_back(rand_printable());
      end
      default: begin
        cut = $urandom_range(0, s.len() - 1);
        for (int unsigned i = 0; i < cut; i++) doc_q.push_back(s[i]);
      end
    endcase
  endfunction

  function automatic void add_tag();
    doc_q.push_back(ChLt);
    if ($urandom_range(3) == 0) doc_q.push_back("/");
    push_mixed(tag_names[$urandom_range(7)]);
    if ($urandom_range(2) == 0) begin
      push_str(" id=");
      add_word();
    end
    if ($urandom_range(9) != 0) doc_q.push_back(ChGt);
  endfunction

  // Script or style block with decoys inside; now and then left open.
  function automatic void add_block();
    string name;
    name = ($urandom_range(1) == 1) ? "style" : "script";
    doc_q.push_back(ChLt);
    push_mixed(name);
    if ($urandom_range(1) == 1) push_str(" type=x");
    doc_q.push_back(ChGt);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(3))
        0: add_word();
        1: doc_q.push_back(ChLt);
        2: begin
          push_str("</");
          push_mixed(name.substr(0, $urandom_range(0, name.len() - 2)));
        end
        default: add_blanks();
      endcase
    end
    if ($urandom_range(9) != 0) begin
      push_str("</");
      push_mixed(name);
      doc_q.push_back(ChGt);
    end
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 4)) doc_q.push_back(8'($urandom_range(1, 255)));
  endfunction

  function automatic void build_doc();
    int unsigned pick;
    repeat ($urandom_range(2, 8)) begin
      pick = $urandom_range(99);
      if (pick < 28) add_word();
      else if (pick < 43) add_blanks();
      else if (pick < 58) add_entity();
      else if (pick < 72) add_tag();
      else if (pick < 84) add_block();
      else if (pick < 94) add_noise();
      else push_str("<>");
    end
  endfunction

  // One request; ready is looked at mid-cycle, the request is taken at the next edge.
  task automatic send_byte(logic [7:0] b, logic eot, logic may_idle);
    logic took;
    if (may_idle) begin
      while ($urandom_range(99) < 20) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid       <= 1'b1;
    in_bus.text_byte   <= b;
    in_bus.end_of_text <= eot;
    do begin
      @(negedge clk);
      took = in_bus.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Send the built text; its last byte closes it. The sender does not idle while sent_n is from 150 to 229.
  task automatic send_doc();
    for (int i = 0; i < doc_q.size(); i++) begin
      send_byte(doc_q[i], i == doc_q.size() - 1, !(sent_n >= 150 && sent_n < 230));
      sent_n++;
    end
    doc_q.delete();
  endtask

  // Receiver: random stalls, one long hold-off that fills the block, one stretch always ready.
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 120 && cyc < 200) out_bus.ready <= 1'b0;
      else if (cyc >= 400 && cyc < 600) out_bus.ready <= 1'b1;
      else out_bus.ready <= ($urandom_range(99) >= 20);
    end
  end

  // Watchdog on cycles in which no request moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_n <= 0;
    end else if (quiet_n >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_n <= quiet_n + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.text_byte   <= 8'h00;
    in_bus.end_of_text <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Leading whitespace, smallest nonzero and largest byte, a decoded entity,
    // a broken entity and an empty tag.
    doc_q.push_back(8'h09);
    doc_q.push_back(8'h01);
    push_str("&lt;&qx<>");
    doc_q.push_back(8'hFF);
    send_doc();
    // Style block with mixed case, then an entity cut off by the end of the text.
    push_str("<sTyle>a</STYLE>&nb");
    send_doc();
    // Unterminated tag, and a zero byte that only ends the text.
    push_str("x<a");
    doc_q.push_back(ChNul);
    send_doc();

    sent_n = 0;
    while (sent_n < RandomBytes) begin
      build_doc();
      send_doc();
    end
    in_bus.valid       <= 1'b0;
    in_bus.end_of_text <= 1'b0;

    while (pending_n != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (err_n == 0 && pending_n == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
